@@ sv/eds_pkg.sv @@
// Shared types and constants for the elevator disk request scheduler.
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

  // Default sizes for the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TRACK_BITS_DEF  = 16;

  // Fixed field widths of the transaction payloads.
  localparam int REQ_TRACK_W = 16;
  localparam int TAG_W       = 16;
  localparam int PCNT_W      = 6;

  // Kind of request carried by an input transaction.
  typedef enum logic {
    REQ_ADD      = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_type_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_e;

  // Input transaction payload.
  typedef struct packed {
    req_type_e               req_type;
    logic [REQ_TRACK_W-1:0]  req_track;
    logic [TAG_W-1:0]        arrival_tag;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    status_e                 status;
    logic [REQ_TRACK_W-1:0]  out_track;
    logic [TAG_W-1:0]        out_tag;
    logic [PCNT_W-1:0]       pending_count;
    logic                    moving_down;
  } rsp_t;

  // Flags from the shared track comparator.
  typedef struct packed {
    logic lt;    // entry track below the key
    logic eq;    // entry track equal to the key
    logic eq_c;  // entry track equal to the current group track
  } cmp_t;

endpackage

`default_nettype wire

@@ sv/eds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module eds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/eds_cmp.sv @@
// Shared track comparator used by every search and insertion step.
`timescale 1ns / 1ps
`default_nettype none

module eds_cmp #(
  parameter int TW = 16
) (
  input  wire logic [TW-1:0] a_i,
  input  wire logic [TW-1:0] b_i,
  input  wire logic [TW-1:0] c_i,
  output eds_pkg::cmp_t      res_o
);

  import eds_pkg::*;

  // Magnitude compare against the key and equality against the group track.
  always_comb begin
    res_o.lt   = (a_i < b_i);
    res_o.eq   = (a_i == b_i);
    res_o.eq_c = (a_i == c_i);
  end

endmodule

`default_nettype wire

@@ sv/elevator_disk_request_scheduler_top.sv @@
// Top level of the LOOK elevator disk request scheduler with its sequencer.
//
//  Channel   Handshake          Payload         Direction
//  --------  -----------------  --------------  ---------
//  request   start / busy       req_i (req_t)   in
//  result    done_o (strobe)    rsp_o (rsp_t)   out
//
// A request is taken when start is high and busy is low; its result appears
// with a one-cycle done_o strobe. A full add, an empty dispatch and an add
// into an empty queue finish in the accept cycle, with the result in the next.
// Other adds walk the sorted store downward one entry per cycle; a dispatch
// reads the highest entry, then makes a full scan and a compaction pass
// through the single RAM port pair.
// Reset is asynchronous; the store needs no clearing pass, since only the
// first count entries are ever read. The result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module elevator_disk_request_scheduler_top #(
  parameter int QUEUE_DEPTH = eds_pkg::QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = eds_pkg::TRACK_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire eds_pkg::req_t req_i,
  output logic       done_o,
  output eds_pkg::rsp_t rsp_o
);

  import eds_pkg::*;

  localparam int TW = TRACK_BITS;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = TW + TAG_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_PUT   = 6'b000100,
    S_LAST  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_SHIFT = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [TW-1:0]   head_q, head_d;
  logic            dir_q, dir_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [TW-1:0]   key_trk_q, key_trk_d;
  logic [TAG_W-1:0] key_tag_q, key_tag_d;
  logic            last_lt_q, last_lt_d;
  logic            first_gt_q, first_gt_d;
  logic            up_found_q, up_found_d;
  logic [CW-1:0]   up_pos_q, up_pos_d;
  logic [TW-1:0]   up_trk_q, up_trk_d;
  logic [TAG_W-1:0] up_tag_q, up_tag_d;
  logic            dn_found_q, dn_found_d;
  logic [CW-1:0]   dn_pos_q, dn_pos_d;
  logic [TW-1:0]   dn_trk_q, dn_trk_d;
  logic [TAG_W-1:0] dn_tag_q, dn_tag_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  logic [TW-1:0]   rd_trk;
  logic [TAG_W-1:0] rd_tag;

  logic [TW-1:0]   cmp_key;
  cmp_t            cmp;
  logic            cmp_gt;
  logic            cmp_le;

  logic [TW-1:0]   trk_in;
  logic [CW-1:0]   last_idx;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic [CW:0]     idx_inc2;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_dec;
  logic            is_last;
  logic            first_gt_now;
  logic            dir_new;
  logic [CW-1:0]   sel_pos;
  logic [CW-1:0]   sel_pos_inc;
  logic [TW-1:0]   sel_trk;
  logic [TAG_W-1:0] sel_tag;

  // Sorted store of pending requests, track above tag.
  eds_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_trk = ram_rdata[EW-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  // The comparator sees the new track while inserting, the head otherwise.
  assign cmp_key = (state_q == S_ADD) ? key_trk_q : head_q;

  eds_cmp #(
    .TW (TW)
  ) u_cmp (
    .a_i   (rd_trk),
    .b_i   (cmp_key),
    .c_i   (dn_trk_q),
    .res_o (cmp)
  );

  assign cmp_gt = !cmp.lt && !cmp.eq;
  assign cmp_le = cmp.lt || cmp.eq;

  // Index arithmetic shared by the sequencer.
  assign trk_in      = TW'(req_i.req_track);
  assign last_idx    = count_q - 1'b1;
  assign idx_inc     = idx_q + 1'b1;
  assign idx_dec     = idx_q - 1'b1;
  assign idx_inc2    = {1'b0, idx_q} + (CW+1)'(2);
  assign count_inc   = count_q + 1'b1;
  assign count_dec   = count_q - 1'b1;
  assign is_last     = (idx_q == last_idx);
  assign sel_pos_inc = sel_pos + 1'b1;

  // Sequencer: insertion walk, dispatch scan and compaction pass.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    dir_d      = dir_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    idx_d      = idx_q;
    key_trk_d  = key_trk_q;
    key_tag_d  = key_tag_q;
    last_lt_d  = last_lt_q;
    first_gt_d = first_gt_q;
    up_found_d = up_found_q;
    up_pos_d   = up_pos_q;
    up_trk_d   = up_trk_q;
    up_tag_d   = up_tag_q;
    dn_found_d = dn_found_q;
    dn_pos_d   = dn_pos_q;
    dn_trk_d   = dn_trk_q;
    dn_tag_d   = dn_tag_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    first_gt_now = first_gt_q;
    dir_new    = dir_q;
    sel_pos    = up_pos_q;
    sel_trk    = up_trk_q;
    sel_tag    = up_tag_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_ADD) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              rsp_d.status    = ST_FULL;
              rsp_d.out_track = '0;
              rsp_d.out_tag   = '0;
              done_d          = 1'b1;
            end else if (count_q == '0) begin
              ram_we          = 1'b1;
              ram_waddr       = '0;
              ram_wdata       = {trk_in, req_i.arrival_tag};
              count_d         = count_inc;
              rsp_d.status    = ST_ADDED;
              rsp_d.out_track = '0;
              rsp_d.out_tag   = '0;
              done_d          = 1'b1;
            end else begin
              key_trk_d = trk_in;
              key_tag_d = req_i.arrival_tag;
              idx_d     = last_idx;
              ram_raddr = last_idx[AW-1:0];
              state_d   = S_ADD;
            end
          end else begin
            if (count_q == '0) begin
              rsp_d.status    = ST_EMPTY;
              rsp_d.out_track = '0;
              rsp_d.out_tag   = '0;
              done_d          = 1'b1;
            end else begin
              ram_raddr = last_idx[AW-1:0];
              state_d   = S_LAST;
            end
          end
        end
      end

      S_ADD: begin
        // Entries with a greater track move up by one slot.
        ram_we    = 1'b1;
        ram_waddr = idx_inc[AW-1:0];
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d     = idx_dec;
            ram_raddr = idx_dec[AW-1:0];
          end
        end else begin
          ram_wdata       = {key_trk_q, key_tag_q};
          count_d         = count_inc;
          rsp_d.status    = ST_ADDED;
          rsp_d.out_track = '0;
          rsp_d.out_tag   = '0;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_PUT: begin
        // The new request goes in front of every stored one.
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata       = {key_trk_q, key_tag_q};
        count_d         = count_inc;
        rsp_d.status    = ST_ADDED;
        rsp_d.out_track = '0;
        rsp_d.out_tag   = '0;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      S_LAST: begin
        // The highest entry decides an upward turnaround.
        last_lt_d  = cmp.lt;
        idx_d      = '0;
        ram_raddr  = '0;
        up_found_d = 1'b0;
        dn_found_d = 1'b0;
        state_d    = S_SCAN;
      end

      S_SCAN: begin
        if (idx_q == '0) begin
          first_gt_d   = cmp_gt;
          first_gt_now = cmp_gt;
        end

        // Upward pick: first entry at or above the head, else the last one.
        if (!up_found_q && (!cmp.lt || is_last)) begin
          up_found_d = 1'b1;
          up_pos_d   = idx_q;
          up_trk_d   = rd_trk;
          up_tag_d   = rd_tag;
        end

        // Downward pick: oldest entry of the highest track at or below the head.
        if ((idx_q == '0) || (cmp_le && (!dn_found_q || !cmp.eq_c))) begin
          dn_pos_d = idx_q;
          dn_trk_d = rd_trk;
          dn_tag_d = rd_tag;
        end
        dn_found_d = dn_found_q || cmp_le;

        if (!is_last) begin
          idx_d     = idx_inc;
          ram_raddr = idx_inc[AW-1:0];
        end else begin
          dir_new = dir_q ? !first_gt_now : last_lt_q;
          if (dir_new) begin
            sel_pos = dn_pos_d;
            sel_trk = dn_trk_d;
            sel_tag = dn_tag_d;
          end else begin
            sel_pos = up_pos_d;
            sel_trk = up_trk_d;
            sel_tag = up_tag_d;
          end
          dir_d           = dir_new;
          head_d          = sel_trk;
          rsp_d.status    = ST_DISPATCHED;
          rsp_d.out_track = REQ_TRACK_W'(sel_trk);
          rsp_d.out_tag   = sel_tag;
          if (sel_pos == last_idx) begin
            count_d = count_dec;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d     = sel_pos;
            ram_raddr = sel_pos_inc[AW-1:0];
            state_d   = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Close the gap left by the dispatched entry.
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_inc2 < {1'b0, count_q}) begin
          idx_d     = idx_inc;
          ram_raddr = idx_inc2[AW-1:0];
        end else begin
          count_d = count_dec;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.pending_count = PCNT_W'(count_d);
    rsp_d.moving_down   = dir_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      dir_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      dir_q   <= dir_d;
      done_q  <= done_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    rsp_q      <= rsp_d;
    idx_q      <= idx_d;
    key_trk_q  <= key_trk_d;
    key_tag_q  <= key_tag_d;
    last_lt_q  <= last_lt_d;
    first_gt_q <= first_gt_d;
    up_found_q <= up_found_d;
    up_pos_q   <= up_pos_d;
    up_trk_q   <= up_trk_d;
    up_tag_q   <= up_tag_d;
    dn_found_q <= dn_found_d;
    dn_pos_q   <= dn_pos_d;
    dn_trk_q   <= dn_trk_d;
    dn_tag_q   <= dn_tag_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ sv/eds_chk.sv @@
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module eds_chk #(
  parameter int QUEUE_DEPTH = eds_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire eds_pkg::req_t req_i,
  input wire logic          done_o,
  input wire eds_pkg::rsp_t rsp_o
);

  import eds_pkg::*;

  // A result follows an accepted transaction or the end of a busy stretch.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a pending transaction");

  // Only a dispatch carries a track and a tag.
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != ST_DISPATCHED)) |->
      ((rsp_o.out_track == '0) && (rsp_o.out_tag == '0)))
    else $error("non-dispatch result with nonzero track or tag");

  // An empty report leaves nothing pending.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_EMPTY)) |-> (rsp_o.pending_count == '0))
    else $error("empty report with pending requests");

  // A rejected add sees a full queue.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_FULL)) |->
      (rsp_o.pending_count == PCNT_W'(QUEUE_DEPTH)))
    else $error("full report with queue not full");

endmodule

bind elevator_disk_request_scheduler_top eds_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_eds_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

@@ tb/sv/tb_elevator_disk_request_scheduler_top.sv @@
// Self-checking testbench for the LOOK elevator disk request scheduler.
`timescale 1ns / 1ps

module tb_elevator_disk_request_scheduler_top;
  import eds_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [REQ_TRACK_W-1:0] TRACK_MASK =
    (TRACK_BITS_DEF >= REQ_TRACK_W) ? '1 : REQ_TRACK_W'((1 << TRACK_BITS_DEF) - 1);

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  // Shadow copy of the scheduler state: sorted store, head and sweep direction.
  logic [REQ_TRACK_W-1:0] shadow_track [DEPTH];
  logic [TAG_W-1:0]       shadow_tag [DEPTH];
  int                     shadow_count;
  logic [REQ_TRACK_W-1:0] shadow_head;
  logic                   shadow_down;

  // Results predicted for accepted transactions, oldest first.
  rsp_t awaited_outcomes [$];
  int   mismatch_count;
  int   result_count;
  bit   gaps_on;

  elevator_disk_request_scheduler_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what);
    $display("ERROR at %0t ns, result %0d: %s", $realtime, result_count, what);
    mismatch_count++;
  endtask

  // Apply one request to the shadow state and return the result it must produce.
  function automatic rsp_t look_schedule(req_t item);
    rsp_t                   outcome;
    logic [REQ_TRACK_W-1:0] trk;
    int                     pos;
    int                     idx;
    outcome        = '0;
    outcome.status = ST_ADDED;
    trk            = item.req_track & TRACK_MASK;
    if (item.req_type == REQ_ADD) begin
      if (shadow_count >= DEPTH) begin
        outcome.status = ST_FULL;
      end else begin
        // Insert behind every stored request whose track is not greater.
        pos = 0;
        while (pos < shadow_count && shadow_track[pos] <= trk) pos++;
        for (idx = shadow_count; idx > pos; idx--) begin
          shadow_track[idx] = shadow_track[idx-1];
          shadow_tag[idx]   = shadow_tag[idx-1];
        end
        shadow_track[pos] = trk;
        shadow_tag[pos]   = item.arrival_tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      outcome.status = ST_EMPTY;
    end else begin
      // Turn around when nothing lies ahead of the head.
      if (!shadow_down) begin
        if (shadow_track[shadow_count-1] < shadow_head) shadow_down = 1'b1;
      end else if (shadow_track[0] > shadow_head) begin
        shadow_down = 1'b0;
      end
      pos = 0;
      if (!shadow_down) begin
        while (pos < shadow_count - 1 && shadow_track[pos] < shadow_head) pos++;
      end else begin
        // Highest track at or below the head, then the oldest on that track.
        idx = shadow_count - 1;
        while (idx > 0 && shadow_track[idx] > shadow_head) idx--;
        pos = idx;
        while (pos > 0 && shadow_track[pos-1] == shadow_track[idx]) pos--;
      end
      outcome.status    = ST_DISPATCHED;
      outcome.out_track = shadow_track[pos];
      outcome.out_tag   = shadow_tag[pos];
      shadow_head       = shadow_track[pos];
      for (idx = pos; idx + 1 < shadow_count; idx++) begin
        shadow_track[idx] = shadow_track[idx+1];
        shadow_tag[idx]   = shadow_tag[idx+1];
      end
      shadow_count--;
    end
    outcome.pending_count = PCNT_W'(shadow_count);
    outcome.moving_down   = shadow_down;
    return outcome;
  endfunction

  // Offer one request until it is taken; the sender may drop start at random cycles.
  task automatic issue_request(req_type_e kind, logic [REQ_TRACK_W-1:0] trk,
                               logic [TAG_W-1:0] tag);
    req_t item;
    req_t junk;
    bit   offered;
    item.req_type    = kind;
    item.req_track   = trk;
    item.arrival_tag = tag;
    do begin
      offered = !(gaps_on && $urandom_range(0, 99) < 28);
      // While idle the payload carries junk that must be ignored.
      junk.req_type    = $urandom_range(0, 1) ? REQ_DISPATCH : REQ_ADD;
      junk.req_track   = REQ_TRACK_W'($urandom);
      junk.arrival_tag = TAG_W'($urandom);
      start <= offered;
      req_i <= offered ? item : junk;
      @(posedge clk_i);
    end while (!(offered && !busy));
    awaited_outcomes.push_back(look_schedule(item));
  endtask

  // Track mix: a narrow band for repeated tracks, the extremes, and the full range.
  function automatic logic [REQ_TRACK_W-1:0] pick_track();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return REQ_TRACK_W'($urandom_range(0, 15));
    if (sel == 4) return $urandom_range(0, 1) ? '1 : '0;
    return REQ_TRACK_W'($urandom);
  endfunction

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin : outcome_check
    rsp_t want;
    if (rst_ni && done_o) begin
      result_count++;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = awaited_outcomes.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_o.status, want.status));
        if (rsp_o.out_track !== want.out_track)
          report_mismatch($sformatf("out_track %h, want %h", rsp_o.out_track,
                                    want.out_track));
        if (rsp_o.out_tag !== want.out_tag)
          report_mismatch($sformatf("out_tag %h, want %h", rsp_o.out_tag, want.out_tag));
        if (rsp_o.pending_count !== want.pending_count)
          report_mismatch($sformatf("pending_count %0d, want %0d", rsp_o.pending_count,
                                    want.pending_count));
        if (rsp_o.moving_down !== want.moving_down)
          report_mismatch($sformatf("moving_down %b, want %b", rsp_o.moving_down,
                                    want.moving_down));
      end
    end
  end

  // Empty dispatch, extreme tracks and tags, equal tracks, and turnarounds both ways.
  task automatic test_corner_cases();
    issue_request(REQ_DISPATCH, 16'h0000, 16'h0000);
    issue_request(REQ_ADD, 16'hFFFF, 16'hFFFF);
    issue_request(REQ_ADD, 16'h0000, 16'h0000);
    issue_request(REQ_ADD, 16'h8000, 16'hAAAA);
    issue_request(REQ_ADD, 16'h8000, 16'h5555);
    issue_request(REQ_ADD, 16'h0000, 16'h1234);
    repeat (4) issue_request(REQ_DISPATCH, 16'hFFFF, 16'hFFFF);
    issue_request(REQ_ADD, 16'h0100, 16'h0001);
    issue_request(REQ_ADD, 16'h7FFF, 16'h0002);
    // Up to the top track, then turn around and come down.
    repeat (2) issue_request(REQ_DISPATCH, 16'h5555, 16'hAAAA);
    issue_request(REQ_ADD, 16'h0100, 16'h0003);
    issue_request(REQ_ADD, 16'h0200, 16'h0004);
    repeat (2) issue_request(REQ_DISPATCH, 16'h0000, 16'h0000);
    issue_request(REQ_ADD, 16'h9000, 16'h0005);
    // A track equal to the head stays downward; the last one turns the sweep up.
    repeat (2) issue_request(REQ_DISPATCH, 16'h0000, 16'h0000);
    issue_request(REQ_DISPATCH, 16'h0000, 16'h0000);
  endtask

  // Fill the store, overflow it, then drain it past empty.
  task automatic test_full_queue();
    repeat (DEPTH) issue_request(REQ_ADD, pick_track(), TAG_W'($urandom));
    repeat (2) issue_request(REQ_ADD, pick_track(), TAG_W'($urandom));
    repeat (DEPTH + 2) issue_request(REQ_DISPATCH, pick_track(), TAG_W'($urandom));
  endtask

  // Alternate fill and drain phases so the head sweeps back and forth over a live queue.
  task automatic test_sweeps(int n_items, bit with_gaps);
    bit filling;
    int high_mark;
    int low_mark;
    bit do_add;
    gaps_on   = with_gaps;
    filling   = 1'b1;
    high_mark = $urandom_range(1, 16);
    low_mark  = 0;
    repeat (n_items) begin
      if (filling && shadow_count >= high_mark) begin
        filling  = 1'b0;
        low_mark = $urandom_range(0, shadow_count);
      end else if (!filling && shadow_count <= low_mark) begin
        filling   = 1'b1;
        high_mark = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(1, 16);
      end
      do_add = filling ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
      issue_request(do_add ? REQ_ADD : REQ_DISPATCH, pick_track(), TAG_W'($urandom));
    end
  endtask

  // Unstructured mix of adds and dispatches.
  task automatic test_noise(int n_items);
    gaps_on = 1'b1;
    repeat (n_items) begin
      issue_request($urandom_range(0, 1) ? REQ_DISPATCH : REQ_ADD,
                    REQ_TRACK_W'($urandom), TAG_W'($urandom));
    end
  endtask

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin : main_sequence
    int waited;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    gaps_on        = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    shadow_count   = 0;
    shadow_head    = '0;
    shadow_down    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    gaps_on = 1'b1;
    test_full_queue();
    test_sweeps(900, 1'b1);
    test_sweeps(300, 1'b0);
    test_noise(300);
    start <= 1'b0;

    // Let the last results come out, then watch for strays.
    waited = 0;
    while (awaited_outcomes.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (awaited_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/eds_pkg.sv
sv/eds_ram.sv
sv/eds_cmp.sv
sv/elevator_disk_request_scheduler_top.sv
sv/eds_chk.sv
tb/sv/tb_elevator_disk_request_scheduler_top.sv
